// File: hdl/bltt_pkg.sv
`default_nettype none

package bltt_pkg;

  // Result operation codes.
  typedef enum logic [3:0] {
    OP_SHR        = 4'd0,
    OP_SHL        = 4'd1,
    OP_INC        = 4'd2,
    OP_DEC        = 4'd3,
    OP_PRINT      = 4'd4,
    OP_LOOP_START = 4'd5,
    OP_LOOP_END   = 4'd6,
    OP_RETURN     = 4'd7,
    OP_ERROR      = 4'd8
  } op_t;

  // Status and sticky error codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DEPTH     = 3'd1,
    ST_EXTRA_END = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_LABELS    = 3'd4
  } status_t;

  // Token classes handed from the front end to the back end.
  typedef enum logic [3:0] {
    TK_SHR,
    TK_SHL,
    TK_INC,
    TK_DEC,
    TK_PRINT,
    TK_OPEN,
    TK_CLOSE,
    TK_RET,
    TK_BAD
  } tok_t;

  // One queue beat, the valid flag and the token, as seen by either side.
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_beat_t;

  localparam logic [7:0] CH_SHR   = 8'h3E;  // '>'
  localparam logic [7:0] CH_SHL   = 8'h3C;  // '<'
  localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] CH_PRINT = 8'h2E;  // '.'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'

  localparam logic CMD_END = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

endpackage

`default_nettype wire

// File: hdl/bracket_loop_token_translator.sv
`default_nettype none

// Channel   Direction  Handshake              Fields
// in_       input      in_valid / in_ready    in_cmd[0:0], in_source_char[7:0]
// out_      output     out_valid / out_ready  out_op[3:0], out_label[15:0], out_status[2:0]
//
// The back end retires one token per clock while the output is not held, bounded by
// the push or pop at the top of the label stack.
// A result appears in the cycle after the back end accepts its token; from input to
// output a beat passes through the queue slot and the result register.
// Reset clears the depth, label counter, sticky error and queue; the stack memory
// is not cleared, so no pass is needed. Ready rises in the cycle after reset is released.
// A stalled output holds the result register; the two-entry queue absorbs the
// front end while the back end waits.

module bracket_loop_token_translator
  import bltt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 512,
  parameter int unsigned LABEL_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_source_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_op,
  output logic [15:0]      out_label,
  output logic [2:0]       out_status
);

  // Tokens pass from the classifier to the queue and on to the stack engine.
  tok_beat_t q_push;
  tok_beat_t q_pop;
  logic      q_push_ready;
  logic      q_pop_ready;

  // Front end: maps each source byte, or the end marker, to a token class.
  bltt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_source_char (in_source_char),
    .q_push         (q_push),
    .q_push_ready   (q_push_ready)
  );

  // Short queue so that a stalled back end does not block the front end at once.
  bltt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_ready  (q_pop_ready)
  );

  // Back end: owns the label stack, the label counter and the sticky error,
  // and registers one result per token.
  bltt_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LABEL_BITS  (LABEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_pop       (q_pop),
    .q_pop_ready (q_pop_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_op      (out_op),
    .out_label   (out_label),
    .out_status  (out_status)
  );

endmodule

`default_nettype wire

// File: hdl/bltt_front.sv
`default_nettype none

module bltt_front
  import bltt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_source_char,
  output tok_beat_t       q_push,
  input  wire logic       q_push_ready
);

  tok_t tok;

  always_comb begin
    if (in_cmd == CMD_END) begin
      tok = TK_RET;
    end else begin
      case (in_source_char)
        CH_SHR:   tok = TK_SHR;
        CH_SHL:   tok = TK_SHL;
        CH_INC:   tok = TK_INC;
        CH_DEC:   tok = TK_DEC;
        CH_PRINT: tok = TK_PRINT;
        CH_OPEN:  tok = TK_OPEN;
        CH_CLOSE: tok = TK_CLOSE;
        default:  tok = TK_BAD;
      endcase
    end
  end

  // Ready is held low during reset so that no beat slips in early.
  logic live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= 1'b1;
    end
  end

  assign in_ready     = q_push_ready && live_r;
  assign q_push.valid = in_valid && live_r;
  assign q_push.tok   = tok;

endmodule

`default_nettype wire

// File: hdl/bltt_queue.sv
`default_nettype none

module bltt_queue
  import bltt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tok_beat_t push,
  output logic           push_ready,
  output tok_beat_t      pop,
  input  wire logic      pop_ready
);

  tok_t             slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r,  count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (QAW+1)'(QDEPTH));
  assign pop.valid  = (count_r != '0);
  assign pop.tok    = slot_r[rd_ptr_r];

  assign do_push = push.valid && push_ready;
  assign do_pop  = pop.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.tok;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bltt_back.sv
`default_nettype none

module bltt_back
  import bltt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 512,
  parameter int unsigned LABEL_BITS  = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tok_beat_t q_pop,
  output logic           q_pop_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [3:0]     out_op,
  output logic [15:0]    out_label,
  output logic [2:0]     out_status
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [AW-1:0] DEPTH_MAX = AW'(STACK_DEPTH - 1);

  // The top of stack lives in tos_r; entries below it are in the memory.
  // below_r always holds the entry under the top once the depth is two or more.
  logic [LABEL_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [LABEL_BITS-1:0] tos_r,   tos_nxt;
  logic [LABEL_BITS-1:0] below_r;
  logic [AW-1:0]         depth_r, depth_nxt;
  logic [LABEL_BITS:0]   nl_r,    nl_nxt;
  status_t               err_r,   err_nxt;

  logic                  fire, do_push, do_pop, rd_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  op_t                   res_op;
  logic [LABEL_BITS-1:0] res_label;
  status_t               res_status;

  logic                  out_valid_r;
  op_t                   out_op_r;
  logic [15:0]           out_label_r;
  status_t               out_status_r;

  assign fire        = q_pop.valid && (!out_valid_r || out_ready);
  assign q_pop_ready = !out_valid_r || out_ready;

  always_comb begin
    res_op     = OP_ERROR;
    res_label  = '0;
    res_status = ST_OK;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    if (err_r != ST_OK) begin
      res_status = err_r;
    end else begin
      case (q_pop.tok)
        TK_SHR:   res_op = OP_SHR;
        TK_SHL:   res_op = OP_SHL;
        TK_INC:   res_op = OP_INC;
        TK_DEC:   res_op = OP_DEC;
        TK_PRINT: res_op = OP_PRINT;
        TK_RET:   res_op = OP_RETURN;
        TK_OPEN: begin
          if (depth_r == DEPTH_MAX) begin
            res_status = ST_DEPTH;
          end else if (nl_r[LABEL_BITS]) begin
            res_status = ST_LABELS;
          end else begin
            res_op    = OP_LOOP_START;
            res_label = nl_r[LABEL_BITS-1:0];
            do_push   = 1'b1;
          end
        end
        TK_CLOSE: begin
          if (depth_r == '0) begin
            res_status = ST_EXTRA_END;
          end else begin
            res_op    = OP_LOOP_END;
            res_label = tos_r;
            do_pop    = 1'b1;
          end
        end
        default:  res_status = ST_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    tos_nxt   = tos_r;
    depth_nxt = depth_r;
    nl_nxt    = nl_r;
    err_nxt   = err_r;
    if (fire) begin
      err_nxt = res_status;
      if (do_push) begin
        tos_nxt   = nl_r[LABEL_BITS-1:0];
        depth_nxt = depth_r + 1'b1;
        nl_nxt    = nl_r + 1'b1;
      end else if (do_pop) begin
        tos_nxt   = below_r;
        depth_nxt = depth_r - 1'b1;
      end
    end
  end

  // A push spills the old top into the memory; a pop prefetches the entry
  // that will sit under the new top.
  assign wr_addr = depth_r - 1'b1;
  assign rd_addr = depth_r - AW'(2'd3);
  assign rd_en   = fire && do_pop && ({1'b0, depth_r} >= (AW+1)'(3));

  always_ff @(posedge clk) begin
    if (fire && do_push && (depth_r != '0)) begin
      stack_mem[wr_addr] <= tos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      below_r <= stack_mem[rd_addr];
    end else if (fire && do_push) begin
      below_r <= tos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      nl_r        <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      nl_r    <= nl_nxt;
      err_r   <= err_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (fire) begin
      out_op_r     <= res_op;
      out_label_r  <= 16'(res_label);
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_op     = out_op_r;
  assign out_label  = out_label_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// File: tb/tb_bracket_loop_token_translator.sv
module tb_bracket_loop_token_translator;
  import bltt_pkg::*;

  // The block is built at its default sizes, and the predictor below uses the same ones.
  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned LABEL_BITS  = 16;
  localparam int unsigned LABEL_LIMIT = 1 << LABEL_BITS;

  // The package only names the end-of-source command, so the other value is named here.
  localparam logic CMD_CHAR = 1'b0;

  // One result beat as the block should present it.
  typedef struct {
    op_t         op;
    logic [15:0] label;
    status_t     status;
  } op_beat_t;

  // Scoreboard class. It keeps its own copy of the label stack, the label counter and the
  // sticky error, and turns every accepted source beat into the op beat that must follow.
  class token_scoreboard;
    logic [15:0] label_mem [STACK_DEPTH];
    int unsigned nest_depth;
    logic [16:0] label_count;
    status_t     sticky;
    op_beat_t    awaited_ops[$];
    int unsigned checked;
    int unsigned fail_count;

    function new();
      nest_depth  = 0;
      label_count = '0;
      sticky      = ST_OK;
      checked     = 0;
      fail_count  = 0;
    endfunction

    // A fault latches its code, and every later beat reports that code.
    function void latch_fault(status_t code, ref op_beat_t beat);
      sticky      = code;
      beat.op     = OP_ERROR;
      beat.status = code;
    endfunction

    function void note_source_beat(logic cmd, logic [7:0] ch);
      op_beat_t beat;
      beat.op     = OP_ERROR;
      beat.label  = '0;
      beat.status = ST_OK;
      if (sticky != ST_OK) begin
        beat.status = sticky;
      end else if (cmd == CMD_END) begin
        // Open loops at the end of the source are not reported.
        beat.op = OP_RETURN;
      end else begin
        case (ch)
          CH_SHR:   beat.op = OP_SHR;
          CH_SHL:   beat.op = OP_SHL;
          CH_INC:   beat.op = OP_INC;
          CH_DEC:   beat.op = OP_DEC;
          CH_PRINT: beat.op = OP_PRINT;
          CH_OPEN: begin
            // The depth check takes precedence over the label check.
            if (nest_depth >= STACK_DEPTH - 1) begin
              latch_fault(ST_DEPTH, beat);
            end else if (label_count >= LABEL_LIMIT) begin
              latch_fault(ST_LABELS, beat);
            end else begin
              label_mem[nest_depth] = label_count[15:0];
              beat.op    = OP_LOOP_START;
              beat.label = label_count[15:0];
              nest_depth++;
              label_count++;
            end
          end
          CH_CLOSE: begin
            if (nest_depth == 0) begin
              latch_fault(ST_EXTRA_END, beat);
            end else begin
              nest_depth--;
              beat.op    = OP_LOOP_END;
              beat.label = label_mem[nest_depth];
            end
          end
          default: latch_fault(ST_UNKNOWN, beat);
        endcase
      end
      awaited_ops.push_back(beat);
    endfunction

    function void check_op_beat(logic [3:0] op, logic [15:0] label, logic [2:0] status);
      op_beat_t want;
      if (awaited_ops.size() == 0) begin
        $display("%0t: op beat op=%0d label=%0d status=%0d arrived with nothing awaited",
                 $time, op, label, status);
        fail_count++;
        return;
      end
      want = awaited_ops.pop_front();
      checked++;
      if (op !== want.op) begin
        $display("%0t: op mismatch, expected %0d, actual %0d", $time, want.op, op);
        fail_count++;
      end
      if (label !== want.label) begin
        $display("%0t: label mismatch, expected %0d, actual %0d", $time, want.label, label);
        fail_count++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return awaited_ops.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [7:0]  in_source_char;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_op;
  logic [15:0] out_label;
  logic [2:0]  out_status;

  token_scoreboard sb = new();

  // Sender pacing: bursts of random length separated by short gaps, unless steady_feed is set.
  int unsigned burst_left  = 0;
  bit          steady_feed = 1'b0;

  // Stimulus-side bookkeeping, so that the generator never depends on when the monitor runs.
  int unsigned open_loops  = 0;
  int unsigned max_open    = 0;
  int unsigned labels_used = 0;
  int unsigned beats_sent  = 0;
  bit          faulted     = 1'b0;

  // Receiver pacing: a mode is held for a window of cycles, then a fresh one is drawn.
  int unsigned ready_mode = 0;
  int unsigned ready_win  = 0;

  bracket_loop_token_translator #(
    .STACK_DEPTH(STACK_DEPTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_source_char(in_source_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_op        (out_op),
    .out_label     (out_label),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver changes out_ready at the falling edge only. The modes are: always ready,
  // randomly ready with a chance of three in four, alternating, and randomly ready with a chance of one in three.
  always @(negedge clk) begin
    if (ready_win == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_win  <= $urandom_range(16, 64);
    end else begin
      ready_win <= ready_win - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ~out_ready;
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Both handshakes are sampled at the rising edge. An input beat is noted before the result
  // of the same edge is checked, although a result never belongs to a beat of that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_source_beat(in_cmd, in_source_char);
      end
      if (out_valid && out_ready) begin
        sb.check_op_beat(out_op, out_label, out_status);
      end
    end
  end

  // Offers one beat and returns at the rising edge where it is taken. A gap lowers valid at
  // one falling edge and raises it at a later one, so valid never gets two updates at once.
  task automatic send_beat(input logic cmd, input logic [7:0] ch);
    int unsigned gap;
    gap = 0;
    if (!steady_feed) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 4);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_source_char <= ch;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Sends one source character and keeps track of the nesting that it should leave behind.
  task automatic send_token(input logic [7:0] ch);
    send_beat(CMD_CHAR, ch);
    if (!faulted) begin
      if (ch == CH_OPEN) begin
        open_loops++;
        labels_used++;
        if (open_loops > max_open) max_open = open_loops;
      end else if (ch == CH_CLOSE && open_loops > 0) begin
        open_loops--;
      end
    end
  endtask

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 4))
      0:       return CH_SHR;
      1:       return CH_SHL;
      2:       return CH_INC;
      3:       return CH_DEC;
      default: return CH_PRINT;
    endcase
  endfunction

  // Drops valid and holds the sender back until every awaited op beat has been seen.
  task automatic idle_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic close_all_loops();
    while (open_loops > 0) send_token(CH_CLOSE);
  endtask

  // Well-formed source with random content. Each segment draws its own leaning towards
  // opening or closing loops, so the nesting wanders between shallow and fairly deep.
  task automatic run_programs(input int unsigned total);
    int unsigned sent;
    int unsigned open_pct;
    int unsigned close_pct;
    int unsigned seg_len;
    int unsigned roll;
    sent = 0;
    while (sent < total) begin
      open_pct  = 5 + 10 * $urandom_range(0, 3);
      close_pct = 5 + 10 * $urandom_range(0, 3);
      seg_len   = $urandom_range(20, 80);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          send_beat(CMD_END, 8'($urandom_range(0, 255)));
        end else if (roll < 6 + open_pct && open_loops < STACK_DEPTH - 2) begin
          send_token(CH_OPEN);
        end else if (roll < 6 + open_pct + close_pct && open_loops > 0) begin
          send_token(CH_CLOSE);
        end else begin
          send_token(plain_char());
        end
        sent++;
      end
    end
  endtask

  initial begin
    status_t     last_fault;
    logic [7:0]  stray;

    // Every input is known from time zero; reset is applied once at the start and never again.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_CHAR;
    in_source_char = 8'h00;
    out_ready      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: every plain op, end of source with both extremes of the ignored byte,
    // nested loops, and an end of source while loops are still open (which is not an error).
    send_token(CH_SHR);
    send_token(CH_SHL);
    send_token(CH_INC);
    send_token(CH_DEC);
    send_token(CH_PRINT);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_END, 8'hFF);
    send_token(CH_OPEN);
    send_token(CH_OPEN);
    send_token(CH_INC);
    send_token(CH_CLOSE);
    send_token(CH_OPEN);
    send_token(CH_PRINT);
    send_token(CH_CLOSE);
    send_token(CH_CLOSE);
    send_token(CH_OPEN);
    send_token(CH_OPEN);
    send_beat(CMD_END, CH_OPEN);
    send_token(CH_CLOSE);
    send_beat(CMD_END, CH_CLOSE);
    send_token(CH_CLOSE);
    send_token(CH_OPEN);
    send_token(CH_CLOSE);

    // The sender rests here until the block has caught up completely.
    idle_until_drained();

    run_programs(1150);
    idle_until_drained();

    // Errors are sticky until reset and reset is applied only once, so a run can show just one
    // kind of fault. The seed picks which one; the others are reached under other seeds.
    case ($urandom_range(0, 3))
      0:       last_fault = ST_DEPTH;
      1:       last_fault = ST_EXTRA_END;
      2:       last_fault = ST_UNKNOWN;
      default: last_fault = ST_LABELS;
    endcase

    case (last_fault)
      ST_DEPTH: begin
        // Fill the stack to one below its size; one more open loop overflows it.
        while (open_loops < STACK_DEPTH - 1) send_token(CH_OPEN);
        faulted = 1'b1;
        send_token(CH_OPEN);
      end
      ST_EXTRA_END: begin
        close_all_loops();
        faulted = 1'b1;
        send_token(CH_CLOSE);
      end
      ST_UNKNOWN: begin
        do begin
          stray = 8'($urandom_range(0, 255));
        end while (stray inside {CH_SHR, CH_SHL, CH_INC, CH_DEC, CH_PRINT,
                                 CH_OPEN, CH_CLOSE});
        faulted = 1'b1;
        send_token(stray);
      end
      default: begin
        // Spend every label in the counter with short loops, fed without sender gaps so
        // that the long stretch stays quick. This also drives every label bit both ways.
        close_all_loops();
        steady_feed = 1'b1;
        while (labels_used < LABEL_LIMIT) begin
          send_token(CH_OPEN);
          if (labels_used < LABEL_LIMIT && $urandom_range(0, 3) == 0) begin
            send_token(CH_OPEN);
            send_token(plain_char());
            send_token(CH_CLOSE);
          end
          send_token(CH_CLOSE);
        end
        steady_feed = 1'b0;
        faulted = 1'b1;
        send_token(CH_OPEN);
      end
    endcase

    // Once latched, the fault must be reported for every kind of beat, end of source included.
    repeat (48) begin
      if ($urandom_range(0, 1) == 0) begin
        send_beat(1'($urandom_range(0, 1)), plain_char());
      end else if ($urandom_range(0, 1) == 0) begin
        send_beat(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
      end else begin
        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    // Let the last op beats out, then keep the clock running so that anything stray can show itself.
    idle_until_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d source beats and %0d checked op beats, nesting up to %0d deep,",
             beats_sent, sb.checked, max_open);
    $display("with %0d loop labels issued, ending on latched fault %s.",
             labels_used, last_fault.name());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legitimate run.
  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
